// File: rtl/core/ase_pkg.sv
// ---------------------------------------------------------------------------
// ARGUS shape evaluator package
// Shared widths, constants, register indexes and the pipeline stage record.
// ---------------------------------------------------------------------------
package ase_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int XI_W          = 22;
  localparam int DATA_W        = 32;
  localparam int CFG_IDX_W     = 2;

  localparam logic [31:0] EXP_M1    = 32'd1580030169;
  localparam int          EXP_LIMIT = 23;
  localparam int          TAYLOR_TERMS = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE_XI   = 2'd0,
    REG_END_POINT  = 2'd1,
    REG_RANGE_LOW  = 2'd2,
    REG_RANGE_HIGH = 2'd3
  } cfg_idx_t;

  // One record per pipeline stage; each stage uses only some of the fields.
  typedef struct packed {
    logic        v;
    logic [31:0] s;
    logic        err;
    logic        zero;
    logic [31:0] rem;
    logic [31:0] q;
    logic [32:0] tt;
    logic [31:0] f;
    logic [4:0]  n;
    logic        big;
    logic [31:0] t;
    logic [31:0] p;
    logic [63:0] w;
    logic [33:0] sum;
    logic [32:0] e;
    logic [31:0] root;
    logic [34:0] srem;
    logic [31:0] d;
  } pipe_t;

endpackage

// File: rtl/core/argus_shape_evaluator.sv
// The pipeline has 129 register stages; its last stage is the output register.
// Throughput: one request per cycle; the whole pipeline advances together and holds
// while a finished result waits on out_ready.
// The stages are the bit-per-stage divider (32), the bit-per-stage square root (32),
// the Taylor series, the exponent scaling multipliers (22) and the single stages.
// Reset clears the valid bits and loads the register defaults.
// ---------------------------------------------------------------------------
// ARGUS shape evaluator
// Computes s*sqrt(1-x^2)*exp(-xi*(1-x^2)) with x = s/m0 in a fixed-point pipeline.
// ---------------------------------------------------------------------------
module argus_shape_evaluator #(
  parameter int FRAC_BITS = ase_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ase_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ase_pkg::DATA_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [31:0]                   in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_density,
  output logic                          out_range_error
);

  localparam int S_SQ   = 33;
  localparam int S_AX   = 34;
  localparam int S_T1   = 35;
  localparam int S_TAY  = 36;
  localparam int S_EC   = S_TAY + 3 * (ase_pkg::TAYLOR_TERMS - 1);
  localparam int S_EXP  = S_EC + 1;
  localparam int S_SQRT = S_EXP + ase_pkg::EXP_LIMIT - 1;
  localparam int S_D1   = S_SQRT + 32;
  localparam int S_D2   = S_D1 + 1;
  localparam int NST    = S_D2 + 1;

  localparam logic [32:0] ONE33 = 33'h1_0000_0000;

  logic [ase_pkg::XI_W-1:0] shape_xi_r;
  logic [31:0]              end_point_r;
  logic [31:0]              range_low_r;
  logic [31:0]              range_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_xi_r   <= '0;
      end_point_r  <= 32'h0001_0000;
      range_low_r  <= '0;
      range_high_r <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      unique case (ase_pkg::cfg_idx_t'(cfg_index))
        ase_pkg::REG_SHAPE_XI:   shape_xi_r   <= cfg_wdata[ase_pkg::XI_W-1:0];
        ase_pkg::REG_END_POINT:  end_point_r  <= cfg_wdata;
        ase_pkg::REG_RANGE_LOW:  range_low_r  <= cfg_wdata;
        ase_pkg::REG_RANGE_HIGH: range_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ase_pkg::pipe_t pipe_r  [0:NST-1];
  ase_pkg::pipe_t pipe_nxt[0:NST-1];
  ase_pkg::pipe_t stg_in  [0:NST-1];
  logic           adv;

  assign adv      = !pipe_r[NST-1].v || out_ready;
  assign in_ready = adv;

  always_comb begin
    stg_in[0]      = '0;
    stg_in[0].v    = in_valid;
    stg_in[0].s    = in_sample;
    stg_in[0].err  = (in_sample < range_low_r) || (in_sample > range_high_r);
    stg_in[0].zero = (end_point_r == 32'd0) || (in_sample >= end_point_r);
    stg_in[0].rem  = in_sample;
  end

  for (genvar i = 1; i < NST; i++) begin : g_link
    assign stg_in[i] = pipe_r[i-1];
  end

  for (genvar i = 0; i < NST; i++) begin : g_st
    localparam int TI   = (i >= S_TAY && i < S_EC) ? i - S_TAY : 0;
    localparam int ROLE = TI % 3;
    localparam int KK   = 2 + TI / 3;
    localparam logic [31:0] MK  = 32'((64'd1 << 32) / KK);
    localparam logic [31:0] K32 = 32'(KK);
    localparam int XJ   = (i >= S_EXP && i < S_SQRT) ? i - S_EC : 1;
    localparam int SI   = (i >= S_SQRT && i < S_D1) ? i - S_SQRT : 0;
    localparam int BP   = (SI < 16) ? 31 - 2 * SI : 1;

    logic [32:0]  r2;
    logic [63:0]  sq;
    logic [54:0]  axp;
    logic [54:0]  ax;
    logic [31:0]  q0;
    logic [31:0]  rr;
    logic [31:0]  qk;
    logic [64:0]  ep;
    logic [1:0]   bits;
    logic [34:0]  rem2;
    logic [34:0]  trial;
    logic [32:0]  rt;
    logic [64:0]  dp;

    always_comb begin
      pipe_nxt[i] = stg_in[i];
      r2    = {stg_in[i].rem, 1'b0};
      sq    = 64'(stg_in[i].q) * 64'(stg_in[i].q);
      axp   = 55'(shape_xi_r) * 55'(stg_in[i].tt);
      ax    = axp >> FRAC_BITS;
      q0    = stg_in[i].w[63:32];
      qk    = q0 * K32;
      rr    = stg_in[i].p - qk;
      ep    = 65'(stg_in[i].e) * 65'(ase_pkg::EXP_M1);
      bits  = (SI < 16) ? stg_in[i].tt[BP -: 2] : 2'b00;
      rem2  = {stg_in[i].srem[32:0], bits};
      trial = {1'b0, stg_in[i].root, 2'b01};
      rt    = stg_in[i].tt[32] ? ONE33 : {1'b0, stg_in[i].root};
      dp    = (i == S_D1) ? 65'(stg_in[i].s) * 65'(rt)
                          : 65'(stg_in[i].p) * 65'(stg_in[i].e);
      if (i >= 1 && i < S_SQ) begin
        // Restoring division: one quotient bit per stage.
        if (r2 >= {1'b0, end_point_r}) begin
          pipe_nxt[i].rem = 32'(r2 - {1'b0, end_point_r});
          pipe_nxt[i].q   = {stg_in[i].q[30:0], 1'b1};
        end else begin
          pipe_nxt[i].rem = r2[31:0];
          pipe_nxt[i].q   = {stg_in[i].q[30:0], 1'b0};
        end
      end else if (i == S_SQ) begin
        pipe_nxt[i].tt = ONE33 - {1'b0, sq[63:32]};
      end else if (i == S_AX) begin
        pipe_nxt[i].big = ax >= (55'(ase_pkg::EXP_LIMIT) << 32);
        pipe_nxt[i].n   = ax[36:32];
        pipe_nxt[i].f   = ax[31:0];
      end else if (i == S_T1) begin
        pipe_nxt[i].t   = stg_in[i].f;
        pipe_nxt[i].sum = 34'h1_0000_0000 - {2'b00, stg_in[i].f};
      end else if (i >= S_TAY && i < S_EC) begin
        if (ROLE == 0) begin
          pipe_nxt[i].w = 64'(stg_in[i].t) * 64'(stg_in[i].f);
        end else if (ROLE == 1) begin
          pipe_nxt[i].p = stg_in[i].w[63:32];
          pipe_nxt[i].w = 64'(stg_in[i].w[63:32]) * 64'(MK);
        end else begin
          // The reciprocal estimate is at most one below the true quotient.
          pipe_nxt[i].t = (rr >= K32) ? q0 + 32'd1 : q0;
          if (KK % 2 == 1) begin
            pipe_nxt[i].sum = stg_in[i].sum - {2'b00, pipe_nxt[i].t};
          end else begin
            pipe_nxt[i].sum = stg_in[i].sum + {2'b00, pipe_nxt[i].t};
          end
        end
      end else if (i == S_EC) begin
        if (stg_in[i].big) begin
          pipe_nxt[i].e = '0;
        end else if (stg_in[i].sum > {1'b0, ONE33}) begin
          pipe_nxt[i].e = ONE33;
        end else begin
          pipe_nxt[i].e = stg_in[i].sum[32:0];
        end
        pipe_nxt[i].root = '0;
        pipe_nxt[i].srem = '0;
      end else if (i >= S_EXP && i < S_SQRT) begin
        if (5'(XJ) <= stg_in[i].n) begin
          pipe_nxt[i].e = ep[64:32];
        end
      end else if (i >= S_SQRT && i < S_D1) begin
        // Digit-by-digit square root of tt * 2^32, one result bit per stage.
        if (rem2 >= trial) begin
          pipe_nxt[i].srem = rem2 - trial;
          pipe_nxt[i].root = {stg_in[i].root[30:0], 1'b1};
        end else begin
          pipe_nxt[i].srem = rem2;
          pipe_nxt[i].root = {stg_in[i].root[30:0], 1'b0};
        end
      end else if (i == S_D1) begin
        pipe_nxt[i].p = dp[63:32];
      end else if (i == S_D2) begin
        pipe_nxt[i].d = (stg_in[i].err || stg_in[i].zero) ? 32'd0 : dp[63:32];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pipe_r[i].v <= 1'b0;
      end else if (adv) begin
        pipe_r[i] <= pipe_nxt[i];
      end
    end
  end

  assign out_valid       = pipe_r[NST-1].v;
  assign out_density     = pipe_r[NST-1].d;
  assign out_range_error = pipe_r[NST-1].err;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_density == 32'd0)
    else $error("range error with nonzero density");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(pipe_r[0].s) && $stable(pipe_r[S_EC].e))
    else $error("pipeline moved during a stall");

  a_exp_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_r[S_EC].v |-> pipe_r[S_EC].e <= ONE33)
    else $error("exponential above one");

  a_d1_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_r[S_D1].v |-> pipe_r[S_D1].p <= pipe_r[S_D1].s)
    else $error("partial product exceeds sample");

endmodule
